@@ rtl/rbtd_pkg.sv @@
// Shared constants, types and the quarter-wave sine table for the tone detector.
`timescale 1ns / 1ps

package rbtd_pkg;

  // Default sizes of the history store.
  localparam int HISTORY_DEPTH_DEF = 64;
  localparam int NODE_COUNT_DEF    = 1024;

  // Field and register widths.
  localparam int NODE_W   = 10;
  localparam int SAMPLE_W = 16;
  localparam int DET_W    = 16;
  localparam int PHASE_W  = 16;
  localparam int OFFSET_W = 8;
  localparam int GAIN_W   = 16;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 4;

  // Datapath widths.
  localparam int DIFF_W     = 17;
  localparam int ACC_PH_W   = 17;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = DIFF_W + COEF_W;
  localparam int NORM_W     = 30;
  localparam int SQ_W       = 2 * NORM_W;
  localparam int SUM_W      = SQ_W + 1;
  localparam int ROOT_W     = 31;
  localparam int SQRT_W     = SUM_W + 1;
  localparam int SQRT_START = 60;
  localparam int SQRT_STEPS = 31;
  localparam int LOG_IN_W   = ROOT_W + 2;
  localparam int LOG_FRAC_W = 16;
  localparam int EXP_W      = 6;
  localparam int LOG_W      = EXP_W + LOG_FRAC_W;
  localparam int LOG_M_W    = 32;
  localparam int LOG_NORM_STEPS = 6;
  localparam int LOG_SHIFT_MAX  = 32;
  localparam int GPROD_W    = LOG_W + GAIN_W;

  localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;
  localparam logic [DET_W-1:0]   DET_MAX      = 16'hFFFF;

  // Register map, by word index.
  localparam logic [1:0] REG_PHASE_STEP     = 2'd0;
  localparam logic [1:0] REG_NEUTRAL_OFFSET = 2'd1;
  localparam logic [1:0] REG_OUTPUT_GAIN    = 2'd2;

  localparam logic [PHASE_W-1:0]  PHASE_STEP_RST     = 16'd8192;
  localparam logic [OFFSET_W-1:0] NEUTRAL_OFFSET_RST = 8'd0;
  localparam logic [GAIN_W-1:0]   OUTPUT_GAIN_RST    = 16'd256;

  // Rotation constants of the sine recurrence, Q30.
  localparam logic [63:0] COS_STEP_Q30 = 64'd1073418433;
  localparam logic [63:0] SIN_STEP_Q30 = 64'd26350944;

  typedef logic [64:0][15:0] qsine_t;

  function automatic qsine_t build_qsine();
    qsine_t      t;
    logic [63:0] prev;
    logic [63:0] cur;
    logic [63:0] q;
    logic [63:0] prod;
    logic [63:0] nxt;
    t    = '0;
    prev = 64'd0;
    cur  = SIN_STEP_Q30;
    for (int k = 1; k <= 64; k++) begin
      q    = (cur + 64'd16384) >> 15;
      t[k] = (q > 64'd32767) ? 16'd32767 : q[15:0];
      prod = (64'd2 * COS_STEP_Q30 * cur + (64'd1 << 29)) >> 30;
      nxt  = (prod >= prev) ? prod - prev : 64'd0;
      prev = cur;
      cur  = nxt;
    end
    return t;
  endfunction

  localparam qsine_t QSINE = build_qsine();

  // Sine of a 16-bit phase in Q1.15, top eight phase bits only.
  function automatic logic signed [COEF_W-1:0] sine_q15(input logic [PHASE_W-1:0] ph);
    logic [7:0]  idx;
    logic [6:0]  off;
    logic [15:0] mag;
    idx = ph[15:8];
    off = {1'b0, idx[5:0]};
    if (idx[6]) begin
      mag = QSINE[7'd64 - off];
    end else begin
      mag = QSINE[off];
    end
    return idx[7] ? -$signed(mag) : $signed(mag);
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       clr_write;
    logic       capture;
    logic       item_write;
    logic       mac_init;
    logic       mac_issue;
    logic       mag_load;
    logic       norm_step;
    logic       sq_step;
    logic       sqrt_load;
    logic       sqrt_step;
    logic       sqrt_store;
    logic       log_load;
    logic       log_norm;
    logic       log_sq;
    logic       log_store;
    logic       finish;
    logic [2:0] sel;
    logic [4:0] step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic node_ok;
    logic mac_last;
    logic mac_busy;
    logic norm_done;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/rbtd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rbtd_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ rtl/rbtd_ctrl.sv @@
// Sequencing state machine of the tone detector.
`timescale 1ns / 1ps

module rbtd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rbtd_pkg::sts_t sts,
  output rbtd_pkg::cmd_t cmd
);
  import rbtd_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WRITE = 4'd2;
  localparam logic [3:0] S_MAC   = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_NORM  = 4'd5;
  localparam logic [3:0] S_SQ    = 4'd6;
  localparam logic [3:0] S_RT_LD = 4'd7;
  localparam logic [3:0] S_RT    = 4'd8;
  localparam logic [3:0] S_RT_ST = 4'd9;
  localparam logic [3:0] S_LG_LD = 4'd10;
  localparam logic [3:0] S_LG_N  = 4'd11;
  localparam logic [3:0] S_LG_S  = 4'd12;
  localparam logic [3:0] S_LG_ST = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [1:0] k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.sel   = {1'b0, k_r};
    cmd.step  = cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.item_write = 1'b1;
        cmd.mac_init   = 1'b1;
        state_nxt      = sts.node_ok ? S_MAC : S_FIN;
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        if (sts.mac_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.mac_busy) begin
          cmd.mag_load = 1'b1;
          state_nxt    = S_NORM;
        end
      end
      S_NORM: begin
        if (sts.norm_done) begin
          k_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = S_SQ;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        cmd.sel     = {k_r, cnt_r[0]};
        if (cnt_r[0]) begin
          state_nxt = S_RT_LD;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_RT_LD: begin
        cmd.sqrt_load = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_RT;
      end
      S_RT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == 5'(SQRT_STEPS - 1)) begin
          state_nxt = S_RT_ST;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_RT_ST: begin
        cmd.sqrt_store = 1'b1;
        cnt_nxt        = '0;
        if (k_r == 2'd2) begin
          k_nxt     = '0;
          state_nxt = S_LG_LD;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_SQ;
        end
      end
      S_LG_LD: begin
        cmd.log_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_LG_N;
      end
      S_LG_N: begin
        cmd.log_norm = 1'b1;
        if (cnt_r == 5'(LOG_NORM_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_LG_S;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_LG_S: begin
        cmd.log_sq = 1'b1;
        if (cnt_r == 5'(LOG_FRAC_W - 1)) begin
          state_nxt = S_LG_ST;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_LG_ST: begin
        cmd.log_store = 1'b1;
        if (k_r == 2'd1) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_LG_LD;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

@@ rtl/rbtd_dp.sv @@
// Datapath: history store, correlation lanes, square root, log2 and output register.
`timescale 1ns / 1ps

module rbtd_dp #(
  parameter int HISTORY_DEPTH = rbtd_pkg::HISTORY_DEPTH_DEF,
  parameter int NODE_COUNT    = rbtd_pkg::NODE_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rbtd_pkg::cmd_t                  cmd,
  output rbtd_pkg::sts_t                  sts,
  input  logic [rbtd_pkg::NODE_W-1:0]     in_node,
  input  logic [rbtd_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                            in_frame_end,
  input  logic [rbtd_pkg::PHASE_W-1:0]    phase_step,
  input  logic [rbtd_pkg::OFFSET_W-1:0]   neutral_offset,
  input  logic [rbtd_pkg::GAIN_W-1:0]     output_gain,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rbtd_pkg::NODE_W-1:0]     out_node_out,
  output logic [rbtd_pkg::DET_W-1:0]      out_detection
);
  import rbtd_pkg::*;

  localparam int MEM_DEPTH = NODE_COUNT * HISTORY_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int PW        = $clog2(HISTORY_DEPTH);
  localparam int ACC_W     = PROD_W + PW + 1;

  function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
    return (p == PW'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Control registers.
  logic [AW-1:0] clr_addr_r;
  logic [PW-1:0] ring_r;
  logic          v1_r, v2_r;
  logic          out_valid_r;

  // Item and working registers.
  logic [NODE_W-1:0]   node_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic                frame_end_r;
  logic                node_ok_r;
  logic [AW-1:0]       base_r;
  logic [PW-1:0]       ptr_r, j_r;
  logic [ACC_PH_W-1:0] ph_r, ph1_r;
  logic signed [PROD_W-1:0] prod_r [6];
  logic signed [ACC_W-1:0]  acc_r  [6];
  logic [ACC_W-1:0]    mag_r [6];
  logic [SUM_W-1:0]    sum_r;
  logic [SQRT_W-1:0]   rt_x_r, rt_q_r, rt_bit_r;
  logic [ROOT_W-1:0]   root_r [3];
  logic [LOG_IN_W-1:0] lx_r;
  logic [EXP_W-1:0]    e_r;
  logic [LOG_FRAC_W-1:0] f_r;
  logic [LOG_W-1:0]    lg_r [2];
  logic [NODE_W-1:0]   out_node_r;
  logic [DET_W-1:0]    out_det_r;

  // History store.
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [DIFF_W-1:0]  mem_wdata, mem_rdata, diff;

  assign diff      = {1'b0, sample_r} - {{(DIFF_W - OFFSET_W){1'b0}}, neutral_offset};
  assign mem_we    = cmd.clr_write | (cmd.item_write & node_ok_r);
  assign mem_waddr = cmd.clr_write ? clr_addr_r : base_r + AW'(ring_r);
  assign mem_wdata = cmd.clr_write ? '0 : diff;
  assign mem_re    = cmd.mac_issue;
  assign mem_raddr = base_r + AW'(ptr_r);

  rbtd_ram #(
    .WIDTH (DIFF_W),
    .DEPTH (MEM_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Angles of the six lanes for the entry whose data is arriving.
  logic [PHASE_W-1:0] ang [6];
  always_comb begin
    ang[0] = ph1_r[PHASE_W-1:0];
    ang[1] = ph1_r[PHASE_W-1:0] + QUARTER_TURN;
    ang[2] = {ph1_r[PHASE_W-2:0], 1'b0};
    ang[3] = {ph1_r[PHASE_W-2:0], 1'b0} + QUARTER_TURN;
    ang[4] = ph1_r[PHASE_W:1];
    ang[5] = ph1_r[PHASE_W:1] + QUARTER_TURN;
  end

  logic norm_done;
  always_comb begin
    norm_done = 1'b1;
    for (int i = 0; i < 6; i++) begin
      if (mag_r[i][ACC_W-1:NORM_W] != '0) norm_done = 1'b0;
    end
  end

  logic [SQ_W-1:0]   sq_val;
  logic [SQRT_W-1:0] rt_trial;
  assign sq_val   = SQ_W'(mag_r[cmd.sel][NORM_W-1:0]) * SQ_W'(mag_r[cmd.sel][NORM_W-1:0]);
  assign rt_trial = rt_q_r + rt_bit_r;

  logic [LOG_IN_W-1:0] top_v, base_v;
  logic [EXP_W-1:0]    lsh;
  logic [LOG_M_W-1:0]  lm;
  logic [2*LOG_M_W-1:0] lprod;
  assign top_v  = {root_r[0], 2'b00};
  assign base_v = {root_r[1], 2'b00} + LOG_IN_W'(root_r[2]);
  assign lsh    = EXP_W'(LOG_SHIFT_MAX >> cmd.step);
  assign lm     = lx_r[LOG_IN_W-1:1];
  assign lprod  = (2*LOG_M_W)'(lm) * (2*LOG_M_W)'(lm);

  // Final scaling and the special cases.
  logic [LOG_W-1:0]   ldiff;
  logic [GPROD_W-1:0] gprod, grnd;
  logic [DET_W-1:0]   det_v;
  assign ldiff = lg_r[0] - lg_r[1];
  assign gprod = GPROD_W'(ldiff) * GPROD_W'(output_gain);
  assign grnd  = gprod + GPROD_W'(1 << (LOG_FRAC_W - 1));
  always_comb begin
    priority if (!node_ok_r || root_r[0] == '0) begin
      det_v = '0;
    end else if (base_v == '0) begin
      det_v = (output_gain != '0) ? DET_MAX : '0;
    end else if (lg_r[0] <= lg_r[1]) begin
      det_v = '0;
    end else if (grnd[GPROD_W-1:LOG_FRAC_W+DET_W] != '0) begin
      det_v = DET_MAX;
    end else begin
      det_v = grnd[LOG_FRAC_W+DET_W-1:LOG_FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      ring_r      <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_write) clr_addr_r <= clr_addr_r + 1'b1;
      if (cmd.finish && frame_end_r) ring_r <= next_pos(ring_r);
      v1_r <= cmd.mac_issue;
      v2_r <= v1_r;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      node_r      <= in_node;
      sample_r    <= in_sample;
      frame_end_r <= in_frame_end;
      node_ok_r   <= (int'(in_node) < NODE_COUNT);
      base_r      <= AW'(int'(in_node) * HISTORY_DEPTH);
    end
    if (cmd.mac_init) begin
      ptr_r <= next_pos(ring_r);
      j_r   <= '0;
      ph_r  <= '0;
    end else if (cmd.mac_issue) begin
      ptr_r <= next_pos(ptr_r);
      j_r   <= j_r + 1'b1;
      ph_r  <= ph_r + {1'b0, phase_step};
      ph1_r <= ph_r;
    end
    for (int i = 0; i < 6; i++) begin
      if (v1_r) begin
        prod_r[i] <= PROD_W'($signed(mem_rdata)) * PROD_W'(sine_q15(ang[i]));
      end
      if (cmd.mac_init) begin
        acc_r[i] <= '0;
      end else if (v2_r) begin
        acc_r[i] <= acc_r[i] + ACC_W'(prod_r[i]);
      end
      if (cmd.mag_load) begin
        mag_r[i] <= acc_r[i][ACC_W-1] ? $unsigned(-acc_r[i]) : $unsigned(acc_r[i]);
      end else if (cmd.norm_step) begin
        mag_r[i] <= mag_r[i] >> 1;
      end
    end
    if (cmd.sq_step) begin
      sum_r <= cmd.sel[0] ? sum_r + SUM_W'(sq_val) : SUM_W'(sq_val);
    end
    if (cmd.sqrt_load) begin
      rt_x_r   <= SQRT_W'(sum_r);
      rt_q_r   <= '0;
      rt_bit_r <= SQRT_W'(1) << SQRT_START;
    end else if (cmd.sqrt_step) begin
      if (rt_x_r >= rt_trial) begin
        rt_x_r <= rt_x_r - rt_trial;
        rt_q_r <= (rt_q_r >> 1) + rt_bit_r;
      end else begin
        rt_q_r <= rt_q_r >> 1;
      end
      rt_bit_r <= rt_bit_r >> 2;
    end
    if (cmd.sqrt_store) root_r[cmd.sel[1:0]] <= rt_q_r[ROOT_W-1:0];
    if (cmd.log_load) begin
      lx_r <= cmd.sel[0] ? base_v : top_v;
      e_r  <= EXP_W'(LOG_IN_W - 1);
      f_r  <= '0;
    end else if (cmd.log_norm) begin
      if ((lx_r >> (EXP_W'(LOG_IN_W) - lsh)) == '0) begin
        lx_r <= lx_r << lsh;
        e_r  <= e_r - lsh;
      end
    end else if (cmd.log_sq) begin
      lx_r <= lprod[2*LOG_M_W-1] ? {lprod[2*LOG_M_W-1:LOG_M_W], 1'b0}
                                 : {lprod[2*LOG_M_W-2:LOG_M_W-1], 1'b0};
      f_r  <= {f_r[LOG_FRAC_W-2:0], lprod[2*LOG_M_W-1]};
    end
    if (cmd.log_store) lg_r[cmd.sel[0]] <= {e_r, f_r};
    if (cmd.finish) begin
      out_node_r <= node_r;
      out_det_r  <= det_v;
    end
  end

  assign sts.clr_last  = (clr_addr_r == AW'(MEM_DEPTH - 1));
  assign sts.node_ok   = node_ok_r;
  assign sts.mac_last  = (j_r == PW'(HISTORY_DEPTH - 1));
  assign sts.mac_busy  = v1_r | v2_r;
  assign sts.norm_done = norm_done;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_node_out  = out_node_r;
  assign out_detection = out_det_r;

endmodule

@@ rtl/ring_buffer_tone_detector.sv @@
// Top level of the ring-buffer tone detector: register port, controller and datapath.
`timescale 1ns / 1ps

// Each input beat carries one node's sample (in_node, in_sample, in_frame_end).
// The neutral offset is removed and the value written into that node's history
// ring; the ring is then correlated against sine and cosine at the target,
// double and half frequency, and the log2 ratio of target to baseline magnitude,
// weighted by output_gain, is returned on the output channel with the node index.
// Items are processed one at a time. From acceptance an item passes through the
// write of the new entry, one read per history entry through the single read
// port of the history RAM, the drain of the multiply pipeline, the scaling of the
// magnitudes, the shared two-bit-a-step square-root unit for the three magnitudes,
// the log2 unit for numerator and denominator and the issue of the result; a node
// index at or past NODE_COUNT goes straight to a zero result. in_ready rises again
// the cycle after the result is issued.
// Results wait in an output register; the next input beat is accepted while a
// result is still waiting, and only the end of that next item stalls if the
// receiver has still not taken the earlier result.
// After reset the history RAM is cleared one entry per cycle, covering all
// NODE_COUNT * HISTORY_DEPTH entries (65536 by default); in_ready stays low
// throughout while register writes are accepted as usual. The ring position
// advances after each item marked with in_frame_end.
module ring_buffer_tone_detector #(
  parameter int HISTORY_DEPTH = rbtd_pkg::HISTORY_DEPTH_DEF,
  parameter int NODE_COUNT    = rbtd_pkg::NODE_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rbtd_pkg::NODE_W-1:0]     in_node,
  input  logic [rbtd_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                            in_frame_end,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rbtd_pkg::NODE_W-1:0]     out_node_out,
  output logic [rbtd_pkg::DET_W-1:0]      out_detection,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rbtd_pkg::ADDR_W-1:0]     paddr,
  input  logic [rbtd_pkg::DATA_W-1:0]     pwdata,
  output logic [rbtd_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);
  import rbtd_pkg::*;

  // Configuration registers, written on the access phase of an APB write.
  logic [PHASE_W-1:0]  phase_step_r;
  logic [OFFSET_W-1:0] neutral_offset_r;
  logic [GAIN_W-1:0]   output_gain_r;
  logic [1:0]          reg_idx;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r     <= PHASE_STEP_RST;
      neutral_offset_r <= NEUTRAL_OFFSET_RST;
      output_gain_r    <= OUTPUT_GAIN_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PHASE_STEP:     phase_step_r     <= pwdata[PHASE_W-1:0];
        REG_NEUTRAL_OFFSET: neutral_offset_r <= pwdata[OFFSET_W-1:0];
        REG_OUTPUT_GAIN:    output_gain_r    <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back; unmapped words read as zero.
  always_comb begin
    unique case (reg_idx)
      REG_PHASE_STEP:     prdata = DATA_W'(phase_step_r);
      REG_NEUTRAL_OFFSET: prdata = DATA_W'(neutral_offset_r);
      REG_OUTPUT_GAIN:    prdata = DATA_W'(output_gain_r);
      default:            prdata = '0;
    endcase
  end

  cmd_t cmd;
  sts_t sts;

  // The controller sequences every step; the datapath only acts on its commands.
  rbtd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rbtd_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .NODE_COUNT    (NODE_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_node        (in_node),
    .in_sample      (in_sample),
    .in_frame_end   (in_frame_end),
    .phase_step     (phase_step_r),
    .neutral_offset (neutral_offset_r),
    .output_gain    (output_gain_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_node_out   (out_node_out),
    .out_detection  (out_detection)
  );

endmodule

@@ rtl/rbtd_checker.sv @@
// Port-level checker for the tone detector, bound to the top level.
`timescale 1ns / 1ps

module rbtd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rbtd_pkg::NODE_W-1:0]   out_node_out,
  input logic [rbtd_pkg::DET_W-1:0]    out_detection,
  input logic                          pready
);

  // A waiting result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_node_out) && $stable(out_detection))
    else $error("result beat changed while stalled");

  // One item at a time: the input closes right after a beat is taken.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in progress");

  // A result never appears in the cycle after an input beat.
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared without processing time");

  // Reset empties the output and holds the input closed for the clearing pass.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("block not quiet after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("register port stalled");

endmodule

bind ring_buffer_tone_detector rbtd_checker u_rbtd_checker (.*);

@@ bench/tb_ring_buffer_tone_detector.sv @@
// Self-checking testbench for the ring-buffer tone detector.
`timescale 1ns / 1ps

module tb_ring_buffer_tone_detector;
  import rbtd_pkg::*;

  localparam int DEPTH       = 64;
  localparam int NODES       = 1024;
  localparam int RANDOM_BEATS = 1600;
  // The watchdog has to outlast the history clear after reset
  // as well as the longest receiver stall on top of the processing of one item.
  localparam int IDLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 400;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [NODE_W-1:0]   in_node = '0;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                in_frame_end = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [NODE_W-1:0]   out_node_out;
  logic [DET_W-1:0]    out_detection;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  always #1 clk = ~clk;

  ring_buffer_tone_detector u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_node(in_node),
    .in_sample(in_sample), .in_frame_end(in_frame_end),
    .out_valid(out_valid), .out_ready(out_ready), .out_node_out(out_node_out),
    .out_detection(out_detection),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Expected detections, oldest first.
  typedef struct {
    logic [NODE_W-1:0] node;
    logic [DET_W-1:0]  det;
  } det_exp_t;
  det_exp_t pending_dets[$];

  // One row of the directed stimulus. Where fixed is set the detection is
  // known by inspection and typed in; otherwise the predictor supplies it.
  typedef struct {
    int unsigned node;
    int unsigned sample;
    bit          frame_end;
    bit          fixed;
    int unsigned det;
  } stim_row_t;
  stim_row_t stim_rows[$];

  // Model of the block: configuration, history rings and the shared ring position.
  logic [PHASE_W-1:0]  mdl_phase;
  logic [OFFSET_W-1:0] mdl_offset;
  logic [GAIN_W-1:0]   mdl_gain;
  int                  hist_mem [NODES*DEPTH];
  int unsigned         ring_pos;
  int                  sine_tab [65];

  int unsigned errors = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned cfg_writes = 0;
  int unsigned idle_cycles = 0;
  bit          rx_stall_off = 1'b0;

  // Quarter-wave sine in Q1.15 from the rotation recurrence.
  task automatic make_sine_tab();
    logic [63:0] prv, cur, q, prod, nxt;
    prv = 64'd0;
    cur = SIN_STEP_Q30;
    sine_tab[0] = 0;
    for (int k = 1; k <= 64; k++) begin
      q = (cur + 64'd16384) >> 15;
      sine_tab[k] = (q > 64'd32767) ? 32767 : int'(q);
      prod = (64'd2 * COS_STEP_Q30 * cur + (64'd1 << 29)) >> 30;
      nxt = (prod >= prv) ? prod - prv : 64'd0;
      prv = cur;
      cur = nxt;
    end
  endtask

  function automatic longint sin_coef(input logic [15:0] ph);
    logic [7:0] idx;
    int         off;
    idx = ph[15:8];
    off = idx[5:0];
    case (idx[7:6])
      2'd0: return sine_tab[off];
      2'd1: return sine_tab[64 - off];
      2'd2: return -sine_tab[off];
      default: return -sine_tab[64 - off];
    endcase
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2 in unsigned Q.16, fraction truncated one squaring at a time.
  function automatic logic [31:0] log2_fix(input logic [63:0] x);
    int unsigned e;
    logic [63:0] m;
    logic [31:0] f;
    e = 63;
    f = 0;
    while (x[e] == 1'b0) e--;
    m = (e > 31) ? x >> (e - 31) : x << (31 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      f = f << 1;
      if (m >= (64'd1 << 32)) begin
        f[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (e << 16) | f;
  endfunction

  // Correlates one node's ring, oldest entry first, and forms the weighted log ratio.
  function automatic logic [DET_W-1:0] tone_score(input int unsigned node);
    longint      acc [6];
    logic [63:0] mag [6];
    logic [63:0] mx, c, dc, hc, base, r;
    logic [31:0] p, lt, lb;
    logic [15:0] pt, pd, ph;
    longint      d;
    int unsigned sh;
    for (int i = 0; i < 6; i++) acc[i] = 0;
    for (int j = 0; j < DEPTH; j++) begin
      d  = hist_mem[node*DEPTH + (ring_pos + 1 + j) % DEPTH];
      p  = 32'(mdl_phase) * 32'(j);
      pt = p[15:0];
      pd = {p[14:0], 1'b0};
      ph = p[16:1];
      acc[0] += d * sin_coef(pt);
      acc[1] += d * sin_coef(pt + QUARTER_TURN);
      acc[2] += d * sin_coef(pd);
      acc[3] += d * sin_coef(pd + QUARTER_TURN);
      acc[4] += d * sin_coef(ph);
      acc[5] += d * sin_coef(ph + QUARTER_TURN);
    end
    mx = 0;
    for (int i = 0; i < 6; i++) begin
      mag[i] = (acc[i] < 0) ? 64'(-acc[i]) : 64'(acc[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    sh = 0;
    while ((mx >> sh) >= (64'd1 << 30)) sh++;
    for (int i = 0; i < 6; i++) mag[i] = mag[i] >> sh;
    c  = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1]);
    dc = int_sqrt(mag[2] * mag[2] + mag[3] * mag[3]);
    hc = int_sqrt(mag[4] * mag[4] + mag[5] * mag[5]);
    if (c == 0) return '0;
    base = 4 * dc + hc;
    if (base == 0) return (mdl_gain != 0) ? DET_MAX : '0;
    lt = log2_fix(4 * c);
    lb = log2_fix(base);
    if (lt <= lb) return '0;
    r = (64'(lt - lb) * 64'(mdl_gain) + 64'd32768) >> 16;
    return (r > 64'd65535) ? DET_MAX : r[15:0];
  endfunction

  // Applies one accepted beat to the model and returns its detection.
  function automatic logic [DET_W-1:0] step_model(input int unsigned node,
                                                  input int unsigned sample,
                                                  input bit fe);
    logic [DET_W-1:0] det;
    hist_mem[node*DEPTH + ring_pos] = int'(sample) - int'(mdl_offset);
    det = tone_score(node);
    if (fe) ring_pos = (ring_pos + 1) % DEPTH;
    return det;
  endfunction

  // Random idle length: mostly short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  // Offers one input beat. Valid stays high across back-to-back beats so that
  // it is never lowered and raised in the same step.
  task automatic send_beat(input int unsigned node, input int unsigned sample,
                           input bit fe, input bit fixed, input int unsigned det);
    int unsigned gap;
    logic [DET_W-1:0] want;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_node      <= node[NODE_W-1:0];
    in_sample    <= sample[SAMPLE_W-1:0];
    in_frame_end <= fe;
    do @(posedge clk); while (!in_ready);
    want = step_model(node, sample, fe);
    if (fixed && want != det[DET_W-1:0]) begin
      $display("%0t model disagrees with typed row: node %0d expected %0d model %0d",
               $time, node, det, want);
    end
    pending_dets.push_back('{node: node[NODE_W-1:0],
                             det: fixed ? det[DET_W-1:0] : want});
    beats_in++;
    @(negedge clk);
  endtask

  task automatic finish_sending();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Register access: setup cycle, then access cycle; pready is always high.
  task automatic apb_access(input int unsigned idx, input logic [31:0] wdata,
                            input bit wr, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes a register, mirrors it in the model and reads it back.
  task automatic set_reg(input int unsigned idx, input logic [31:0] val);
    logic [31:0] rd, mask;
    apb_access(idx, val, 1'b1, rd);
    cfg_writes++;
    case (idx)
      REG_PHASE_STEP:     begin mdl_phase  = val[15:0]; mask = 32'hFFFF; end
      REG_NEUTRAL_OFFSET: begin mdl_offset = val[7:0];  mask = 32'hFF;   end
      REG_OUTPUT_GAIN:    begin mdl_gain   = val[15:0]; mask = 32'hFFFF; end
      default:            mask = 32'h0;
    endcase
    if (mask != 0) begin
      apb_access(idx, 32'h0, 1'b0, rd);
      if ((rd & mask) != (val & mask)) begin
        $display("%0t register %0d readback: expected %0h actual %0h",
                 $time, idx, val & mask, rd & mask);
        errors++;
      end
    end
  endtask

  task automatic set_config(input int unsigned ph, input int unsigned ofs,
                            input int unsigned gain);
    set_reg(REG_PHASE_STEP, ph);
    set_reg(REG_NEUTRAL_OFFSET, ofs);
    set_reg(REG_OUTPUT_GAIN, gain);
  endtask

  // Waits until every expected detection has come back, so the block is idle.
  task automatic wait_drained();
    while (pending_dets.size() != 0) @(negedge clk);
  endtask

  task automatic run_rows(input int first, input int last);
    for (int i = first; i <= last; i++) begin
      send_beat(stim_rows[i].node, stim_rows[i].sample, stim_rows[i].frame_end,
                stim_rows[i].fixed, stim_rows[i].det);
    end
    finish_sending();
    wait_drained();
  endtask

  // The receiver: random stalls, with quiet stretches now and then.
  initial begin
    int unsigned g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_stall_off || $urandom_range(9) < 3) begin
        out_ready <= 1'b1;
      end else begin
        g = gap_len();
        if (g != 0) begin
          out_ready <= 1'b0;
          repeat (g) @(negedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Result checker: each accepted beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (pending_dets.size() == 0) begin
        $display("%0t unexpected result: node %0d detection %0d",
                 $time, out_node_out, out_detection);
        errors++;
      end else begin
        if (out_node_out !== pending_dets[0].node) begin
          $display("%0t node_out mismatch: expected %0d actual %0d",
                   $time, pending_dets[0].node, out_node_out);
          errors++;
        end
        if (out_detection !== pending_dets[0].det) begin
          $display("%0t detection mismatch (node %0d): expected %0d actual %0d",
                   $time, pending_dets[0].node, pending_dets[0].det, out_detection);
          errors++;
        end
        void'(pending_dets.pop_front());
      end
    end
  end

  // Watchdog: counts cycles in which no beat moves on either channel or the
  // register port.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_ring_buffer_tone_detector NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned n_sent, nd, sp, r;
    bit          fe;
    make_sine_tab();
    for (int i = 0; i < NODES*DEPTH; i++) hist_mem[i] = 0;
    ring_pos   = 0;
    mdl_phase  = PHASE_STEP_RST;
    mdl_offset = NEUTRAL_OFFSET_RST;
    mdl_gain   = OUTPUT_GAIN_RST;

    // Group one, reset configuration. A history that is still all zero
    // correlates to nothing, so the first touch of a node with a zero sample
    // gives zero.
    stim_rows.push_back('{0,    0,      1'b0, 1'b1, 0});
    stim_rows.push_back('{1023, 0,      1'b0, 1'b1, 0});
    stim_rows.push_back('{0,    16'hFFFF, 1'b0, 1'b0, 0});
    stim_rows.push_back('{0,    1,      1'b1, 1'b0, 0});
    stim_rows.push_back('{5,    16'h8000, 1'b0, 1'b0, 0});
    stim_rows.push_back('{1023, 16'hFFFF, 1'b1, 1'b0, 0});
    stim_rows.push_back('{0,    16'h5555, 1'b1, 1'b0, 0});
    stim_rows.push_back('{0,    16'hAAAA, 1'b1, 1'b0, 0});
    stim_rows.push_back('{0,    16'h0100, 1'b1, 1'b0, 0});
    stim_rows.push_back('{682,  16'h7FFF, 1'b0, 1'b0, 0});
    stim_rows.push_back('{341,  16'h00FF, 1'b1, 1'b0, 0});
    // Group two, zero gain: every detection is zero, the zero-baseline case too.
    stim_rows.push_back('{0,    16'hFFFF, 1'b1, 1'b1, 0});
    stim_rows.push_back('{1023, 16'h1234, 1'b0, 1'b1, 0});
    stim_rows.push_back('{5,    16'h0000, 1'b1, 1'b1, 0});
    // Group three, zero phase step: all three magnitudes are equal, so the
    // log ratio is negative and clamped to zero.
    stim_rows.push_back('{0,    16'hFFFF, 1'b1, 1'b1, 0});
    stim_rows.push_back('{5,    16'h0000, 1'b0, 1'b1, 0});
    stim_rows.push_back('{1023, 16'h8001, 1'b1, 1'b1, 0});
    // Group four, largest settings: a full offset drives differences negative.
    stim_rows.push_back('{0,    16'h0000, 1'b1, 1'b0, 0});
    stim_rows.push_back('{0,    16'hFFFF, 1'b1, 1'b0, 0});
    stim_rows.push_back('{1023, 16'h00FE, 1'b0, 1'b0, 0});
    stim_rows.push_back('{341,  16'h0000, 1'b1, 1'b0, 0});

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Register writes are accepted while the history clear is still running.
    // An index past the three registers must be ignored.
    set_config(PHASE_STEP_RST, NEUTRAL_OFFSET_RST, OUTPUT_GAIN_RST);
    set_reg(3, 32'hFFFF_FFFF);
    run_rows(0, 10);
    set_config(16'd1234, 8'd17, 16'd0);
    run_rows(11, 13);
    set_config(16'd0, 8'd0, 16'd256);
    run_rows(14, 16);
    set_config(16'hFFFF, 8'hFF, 16'hFFFF);
    run_rows(17, 20);

    // Random part. Most beats go to a handful of nodes so that their rings fill
    // with real content; the rest spread over the whole node range. Every 200
    // beats the stream drains and a fresh configuration is loaded.
    n_sent = 0;
    while (n_sent < RANDOM_BEATS) begin
      if (n_sent % 200 == 0) begin
        finish_sending();
        wait_drained();
        r = $urandom_range(5);
        case (r)
          0: set_config(16'd8192, 8'd0, 16'd256);
          1: set_config(16'd0, 8'd255, 16'd65535);
          2: set_config(16'd65535, 8'd0, 16'd1);
          default: set_config($urandom_range(65535), $urandom_range(255),
                              $urandom_range(65535));
        endcase
        rx_stall_off = ($urandom_range(3) == 0);
      end
      r  = $urandom_range(99);
      nd = (r < 80) ? $urandom_range(7) : $urandom_range(NODES - 1);
      r  = $urandom_range(99);
      if (r < 5) sp = 0;
      else if (r < 10) sp = 16'hFFFF;
      else if (r < 40) sp = $urandom_range(16'h0200);
      else sp = $urandom_range(16'hFFFF);
      fe = ($urandom_range(3) == 0);
      send_beat(nd, sp, fe, 1'b0, 0);
      n_sent++;
    end
    finish_sending();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d input beats and %0d results over %0d register writes,",
             beats_in, beats_out, cfg_writes);
    $display("including zero gain, zero phase step, full offset and random settings.");
    if (errors == 0 && pending_dets.size() == 0) begin
      $display("tb_ring_buffer_tone_detector OK");
    end else begin
      $display("tb_ring_buffer_tone_detector NOT OK");
    end
    $finish;
  end

endmodule

@@ ring_buffer_tone_detector.f @@
rtl/rbtd_pkg.sv
rtl/rbtd_ram.sv
rtl/rbtd_ctrl.sv
rtl/rbtd_dp.sv
rtl/ring_buffer_tone_detector.sv
rtl/rbtd_checker.sv
bench/tb_ring_buffer_tone_detector.sv
